>>> rtl/pulse_tachometer_bar_graph_macros.svh
// ----------------------------------------------------------------------------
// Tachometer assertion macros
// Immediate-consequence and next-cycle property checks on the block clock.
// ----------------------------------------------------------------------------
`ifndef PULSE_TACHOMETER_BAR_GRAPH_MACROS_SVH
`define PULSE_TACHOMETER_BAR_GRAPH_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TACH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tachometer check failed");
`define TACH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tachometer check failed");
`else
`define TACH_ASSERT_NOW(label, ante, cons)
`define TACH_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/ptbg_pkg.sv
// ----------------------------------------------------------------------------
// Tachometer package
// Sizes of the shared divider and the bar pattern encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptbg_pkg;

  localparam int LedCount = 16;
  localparam int LitW     = $clog2(LedCount + 1);
  localparam int Blocks   = ((LedCount + 7) / 8) < 2 ? ((LedCount + 7) / 8) : 2;

  localparam int DivW = 26;
  localparam int DvsW = 36;
  localparam int CntW = $clog2(DivW);
  localparam int MulW = 40;

  localparam logic [DivW-1:0] MinuteUs = DivW'(60000000);
  localparam logic [31:0]     SecondUs = 32'd1000000;

  function automatic logic [15:0] bar_for_leds(input logic [LitW-1:0] lit);
    logic [15:0] pat;
    logic [7:0]  part_byte;
    int          full;
    pat       = '0;
    full      = int'(lit) / 8;
    part_byte = ~(8'hFF >> lit[2:0]);
    for (int i = 0; i < Blocks; i++) begin
      if (i < full) begin
        pat[8*i +: 8] = 8'hFF;
      end else if (i == full) begin
        pat[8*i +: 8] = part_byte;
      end else begin
        pat[8*i +: 8] = 8'h00;
      end
    end
    return pat;
  endfunction

endpackage

>>> rtl/pulse_tachometer_bar_graph.sv
// ----------------------------------------------------------------------------
// Pulse tachometer with LED bar graph
// Period-measuring tachometer: speed from pulse gap, then LED count and bar.
// ----------------------------------------------------------------------------
// Each input word is the microsecond timestamp of one tacho pulse, and each
// one yields one output word with the held speed, the lit LED count and the
// bar pattern. The block takes one word at a time and stalls its input
// meanwhile. A pulse whose gap is short enough to be measured sets a new
// speed; one whose gap is too long clears the speed; one that keeps the held
// speed skips the speed measurement. A single restoring divider, one quotient
// bit per cycle over 26 bits, is run for the speed when the gap is measured
// and always for the LED count, with one shared 8 by 32 bit multiplier
// forming the measurement window and the divisor.
// A result that the receiver has not yet taken holds the next one back.
`timescale 1ns / 1ps
`include "pulse_tachometer_bar_graph_macros.svh"

module pulse_tachometer_bar_graph (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [31:0]          timestamp_us_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [15:0]          speed_rpm_o,
  output logic [4:0]           lit_count_o,
  output logic [15:0]          bar_pattern_o
);
  import ptbg_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WIN   = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_DIV1  = 7'b0001000,
    S_LOAD2 = 7'b0010000,
    S_DIV2  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  localparam logic RegPpr = 1'b0;
  localparam logic RegFs  = 1'b1;

  state_e           state_q, state_d;
  logic [7:0]       ppr_q;
  logic [15:0]      fs_q;
  logic [31:0]      last_q;
  logic [31:0]      gap_q;
  logic [15:0]      held_q;
  logic [MulW-1:0]  mul_q;
  logic [DvsW-1:0]  rem_q;
  logic [DivW-1:0]  quo_q;
  logic [DvsW-1:0]  dvs_q;
  logic [CntW-1:0]  cnt_q;
  logic [LitW-1:0]  lit_q;
  logic             out_valid_q;
  logic [15:0]      speed_out_q;
  logic [4:0]       lit_out_q;
  logic [15:0]      bar_out_q;

  logic             cfg_write;
  logic             in_accept;
  logic [31:0]      mul_b;
  logic [MulW-1:0]  mul_res;
  logic [DvsW:0]    trial;
  logic [DvsW:0]    diff;
  logic             ge;
  logic [DivW-1:0]  quo_next;
  logic             short_gap;
  logic [15:0]      speed_sat;
  logic [LitW-1:0]  lit_sat;
  logic             out_free;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign in_accept = in_valid_i & ~in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    case (paddr[2])
      RegPpr:  prdata = {24'd0, ppr_q};
      RegFs:   prdata = {16'd0, fs_q};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q <= 8'd1;
      fs_q  <= 16'd16000;
    end else if (cfg_write) begin
      case (paddr[2])
        RegPpr:  ppr_q <= pwdata[7:0];
        RegFs:   fs_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign mul_b     = (state_q == S_WIN) ? SecondUs : gap_q;
  assign mul_res   = MulW'(ppr_q) * MulW'(mul_b);
  assign short_gap = MulW'(gap_q) < mul_q;

  assign trial    = {rem_q, quo_q[DivW-1]};
  assign ge       = trial >= {1'b0, dvs_q};
  assign diff     = trial - {1'b0, dvs_q};
  assign quo_next = {quo_q[DivW-2:0], ge};

  assign speed_sat = (|quo_next[DivW-1:16]) ? 16'hFFFF : quo_next[15:0];
  assign lit_sat   = ((fs_q == 16'd0) || (quo_next > DivW'(LedCount))) ?
                     LitW'(LedCount) : quo_next[LitW-1:0];

  assign out_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if ((last_q != 32'd0) && (last_q < timestamp_us_i)) begin
            state_d = S_WIN;
          end else begin
            state_d = S_LOAD2;
          end
        end
      end
      S_WIN:   state_d = S_MUL;
      S_MUL:   state_d = short_gap ? S_DIV1 : S_LOAD2;
      S_DIV1:  state_d = (cnt_q == '0) ? S_LOAD2 : S_DIV1;
      S_LOAD2: state_d = S_DIV2;
      S_DIV2:  state_d = (cnt_q == '0) ? S_DONE : S_DIV2;
      S_DONE:  state_d = out_free ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        last_q <= timestamp_us_i;
      end
      if ((state_q == S_MUL) && !short_gap) begin
        held_q <= '0;
      end else if ((state_q == S_DIV1) && (cnt_q == '0)) begin
        held_q <= speed_sat;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      gap_q <= timestamp_us_i - last_q;
    end
    if ((state_q == S_WIN) || (state_q == S_MUL)) begin
      mul_q <= mul_res;
    end
    case (state_q)
      S_MUL: begin
        rem_q <= '0;
        quo_q <= MinuteUs;
        dvs_q <= mul_res[DvsW-1:0];
        cnt_q <= CntW'(DivW - 1);
      end
      S_LOAD2: begin
        rem_q <= '0;
        quo_q <= DivW'(held_q) * DivW'(LedCount);
        dvs_q <= DvsW'(fs_q);
        cnt_q <= CntW'(DivW - 1);
      end
      S_DIV1, S_DIV2: begin
        rem_q <= ge ? diff[DvsW-1:0] : trial[DvsW-1:0];
        quo_q <= quo_next;
        cnt_q <= cnt_q - 1'b1;
      end
      default: ;
    endcase
    if ((state_q == S_DIV2) && (cnt_q == '0)) begin
      lit_q <= lit_sat;
    end
    if ((state_q == S_DONE) && out_free) begin
      speed_out_q <= held_q;
      lit_out_q   <= 5'(lit_q);
      bar_out_q   <= bar_for_leds(lit_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign speed_rpm_o   = speed_out_q;
  assign lit_count_o   = lit_out_q;
  assign bar_pattern_o = bar_out_q;

  `TACH_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall_o)
  `TACH_ASSERT_NOW(a_lit_in_range, out_valid_o, lit_count_o <= 5'(LedCount))
  `TACH_ASSERT_NOW(a_full_bar, out_valid_o && (lit_count_o == 5'(LedCount)), bar_pattern_o == 16'hFFFF)

endmodule
